@@ rtl/bae_pkg.sv @@
// shared types and constants of the block average error estimator
// no dependencies
package bae_pkg;

	localparam int FIFO_DEPTH = 4;

	// register index taken from paddr[2]
	localparam logic REG_BLOCK_LENGTH = 1'b0;
	localparam logic REG_NUM_BLOCKS   = 1'b1;

	localparam logic [15:0] BLOCK_LENGTH_RESET = 16'd1000;
	localparam logic [15:0] NUM_BLOCKS_RESET   = 16'd100;

	// one completed block handed from front to back
	typedef struct packed {
		logic signed [47:0] sum;
		logic [15:0]        count;
		logic [15:0]        k;
	} blk_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_M,
		ST_MUL_M,
		ST_ACC,
		ST_DIV_MEAN,
		ST_DIV_A2,
		ST_MUL_Q,
		ST_VAR,
		ST_DIV_VAR,
		ST_SQRT,
		ST_OUT
	} back_state_t;

endpackage

@@ rtl/bae_if.sv @@
// sample and result channels of the estimator
// no dependencies
interface bae_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic               restart;
	modport source (output valid, sample, restart, input ready);
	modport sink (input valid, sample, restart, output ready);
endinterface

interface bae_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        block_index;
	logic signed [31:0] running_mean;
	logic [30:0]        std_error;
	modport source (output valid, block_index, running_mean, std_error, input ready);
	modport sink (input valid, block_index, running_mean, std_error, output ready);
endinterface

@@ rtl/block_average_error_estimator.sv @@
// block average error estimator: samples enter at one per cycle while the block queue has room
// a block result follows its last sample transfer once the back part is free: four divides on one
// shared divider (two and no square root for the first block of a run), a 32-step square root
// and single steps of multiply, add and handoff
// short blocks stall input on a full queue while the back part is busy
// async reset clears the front-part sums and counters and sets block_length 1000, num_blocks 100
module block_average_error_estimator
	import bae_pkg::*;
#(
	parameter int SAMPLE_FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bae_in_if.sink      in_ch,
	bae_out_if.source   out_ch
);

	logic [15:0] block_length_q;
	logic [15:0] num_blocks_q;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	blk_t        push_data;
	blk_t        head;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	assign pready = 1'b1;
	assign prdata = {16'd0, (paddr[2] == REG_NUM_BLOCKS) ? num_blocks_q : block_length_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= BLOCK_LENGTH_RESET;
			num_blocks_q   <= NUM_BLOCKS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_BLOCK_LENGTH)
				block_length_q <= pwdata[15:0];
			else
				num_blocks_q <= pwdata[15:0];
		end
	end

	bae_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.block_length (block_length_q),
		.num_blocks   (num_blocks_q),
		.full         (full),
		.push         (push),
		.push_data    (push_data)
	);

	bae_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.full      (full),
		.empty     (empty)
	);

	bae_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bae_back #(
		.FRAC (SAMPLE_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.out_ch  (out_ch)
	);

endmodule

@@ rtl/bae_div.sv @@
// iterative unsigned divider, 64 by 16 bits, one quotient bit per cycle
// depends on bae_pkg
module bae_div
	import bae_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [16:0] rem_sh;
	logic        q_bit;
	logic [16:0] rem_diff;

	always_comb begin
		rem_sh   = {rem_q, dvd_q[63]};
		q_bit    = rem_sh >= {1'b0, dsr_q};
		rem_diff = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], q_bit};
			rem_q <= q_bit ? rem_diff[15:0] : rem_sh[15:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

@@ rtl/bae_fifo.sv @@
// short queue of completed blocks between front and back
// depends on bae_pkg
module bae_fifo
	import bae_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  blk_t push_data,
	input  logic pop,
	output blk_t pop_data,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	blk_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W+1)'(FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ rtl/bae_front.sv @@
// front part: takes samples, sums blocks and queues each completed block
// depends on bae_pkg and bae_if
module bae_front
	import bae_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bae_in_if.sink      in_ch,
	input  logic [15:0] block_length,
	input  logic [15:0] num_blocks,
	input  logic        full,
	output logic        push,
	output blk_t        push_data
);

	logic signed [47:0] sum_q;
	logic [15:0]        cnt_q;
	logic [15:0]        done_q;

	logic               accept;
	logic signed [47:0] sum_e;
	logic [15:0]        cnt_e;
	logic [15:0]        done_e;
	logic               active;
	logic [15:0]        len;
	logic signed [47:0] new_sum;
	logic [15:0]        new_cnt;
	logic               complete;

	assign in_ch.ready = !full;

	always_comb begin
		accept   = in_ch.valid && in_ch.ready;
		sum_e    = in_ch.restart ? '0 : sum_q;
		cnt_e    = in_ch.restart ? '0 : cnt_q;
		done_e   = in_ch.restart ? '0 : done_q;
		active   = done_e < num_blocks;
		len      = (block_length == '0) ? 16'd1 : block_length;
		new_sum  = sum_e + {{16{in_ch.sample[31]}}, in_ch.sample};
		new_cnt  = cnt_e + 16'd1;
		complete = new_cnt >= len;
		push     = accept && active && complete;
		push_data.sum   = new_sum;
		push_data.count = new_cnt;
		push_data.k     = done_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			done_q <= '0;
		end else if (accept) begin
			sum_q  <= sum_e;
			cnt_q  <= cnt_e;
			done_q <= done_e;
			if (active) begin
				if (complete) begin
					sum_q  <= '0;
					cnt_q  <= '0;
					done_q <= done_e + 16'd1;
				end else begin
					sum_q <= new_sum;
					cnt_q <= new_cnt;
				end
			end
		end
	end

endmodule

@@ rtl/bae_back.sv @@
// back part: block mean, running sums, progressive mean and error per block
// depends on bae_pkg, bae_if; drives the shared divider
module bae_back
	import bae_pkg::*;
#(
	parameter int FRAC = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  blk_t     head,
	output logic     pop,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	bae_out_if.source out_ch
);

	localparam logic [63:0] RAD_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC;

	back_state_t        state_q, state_d;
	blk_t               cur_q;
	logic               start_q;
	logic [63:0]        dvd_q;
	logic [15:0]        dsr_q;
	logic               m_neg_q;
	logic [31:0]        m_mag_q;
	logic [63:0]        prod_q;
	logic signed [47:0] sums_q;
	logic [63:0]        sum2_q;
	logic signed [31:0] mean_q;
	logic [31:0]        mean_mag_q;
	logic [63:0]        a2_q;
	logic [63:0]        sx_q;
	logic [63:0]        sres_q;
	logic [63:0]        sbit_q;
	logic [4:0]         step_q;
	logic [30:0]        err_q;
	logic               out_valid_q;
	logic [15:0]        out_idx_q;
	logic signed [31:0] out_mean_q;
	logic [30:0]        out_err_q;

	logic               out_load;
	logic [15:0]        n;
	logic signed [47:0] m48;
	logic [63:0]        sq;
	logic signed [47:0] sums_new;
	logic [64:0]        sum2_add;
	logic [63:0]        sum2_new;
	logic [47:0]        sums_abs;
	logic [63:0]        qsq;
	logic [63:0]        rad;
	logic [63:0]        s_trial;
	logic               s_take;
	logic [63:0]        sres_n;

	always_comb begin
		n        = cur_q.k + 16'd1;
		m48      = m_neg_q ? -{16'd0, m_mag_q} : {16'd0, m_mag_q};
		sq       = prod_q >> FRAC;
		sums_new = (cur_q.k == '0) ? m48 : sums_q + m48;
		sum2_add = {1'b0, sum2_q} + {1'b0, sq};
		if (cur_q.k == '0)
			sum2_new = sq;
		else
			sum2_new = sum2_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum2_add[63:0];
		sums_abs = sums_new[47] ? 48'(-sums_new) : 48'(sums_new);
		qsq      = prod_q >> FRAC;
		rad      = (div_rsp.quotient > RAD_LIMIT) ? 64'hFFFF_FFFF_FFFF_FFFF
		           : (div_rsp.quotient << FRAC);
		s_trial  = sres_q + sbit_q;
		s_take   = sx_q >= s_trial;
		sres_n   = s_take ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
	end

	assign div_req.start    = start_q;
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dsr_q;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.block_index  = out_idx_q;
	assign out_ch.running_mean = out_mean_q;
	assign out_ch.std_error    = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = ST_DIV_M;
				end
			end
			ST_DIV_M:    if (div_rsp.done) state_d = ST_MUL_M;
			ST_MUL_M:    state_d = ST_ACC;
			ST_ACC:      state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (div_rsp.done)
					state_d = (cur_q.k == '0) ? ST_OUT : ST_DIV_A2;
			end
			ST_DIV_A2:   if (div_rsp.done) state_d = ST_MUL_Q;
			ST_MUL_Q:    state_d = ST_VAR;
			ST_VAR:      state_d = ST_DIV_VAR;
			ST_DIV_VAR:  if (div_rsp.done) state_d = ST_SQRT;
			ST_SQRT:     if (step_q == 5'd31) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_IDLE && !empty) || state_q == ST_ACC
			           || (state_q == ST_DIV_MEAN && div_rsp.done && cur_q.k != '0)
			           || state_q == ST_VAR;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					cur_q <= head;
					dvd_q <= {16'd0, head.sum[47] ? 48'(-head.sum) : 48'(head.sum)};
					dsr_q <= head.count;
				end
			end
			ST_DIV_M: begin
				m_mag_q <= div_rsp.quotient[31:0];
				m_neg_q <= cur_q.sum[47];
			end
			ST_MUL_M: prod_q <= 64'(m_mag_q) * 64'(m_mag_q);
			ST_ACC: begin
				sums_q <= sums_new;
				sum2_q <= sum2_new;
				dvd_q  <= {16'd0, sums_abs};
				dsr_q  <= n;
			end
			ST_DIV_MEAN: begin
				mean_mag_q <= div_rsp.quotient[31:0];
				mean_q     <= sums_q[47] ? -div_rsp.quotient[31:0] : div_rsp.quotient[31:0];
				err_q      <= '0;
				dvd_q      <= sum2_q;
				dsr_q      <= n;
			end
			ST_DIV_A2: a2_q <= div_rsp.quotient;
			ST_MUL_Q:  prod_q <= 64'(mean_mag_q) * 64'(mean_mag_q);
			ST_VAR: begin
				// a negative variance from rounding divides zero instead
				dvd_q <= (a2_q > qsq) ? (a2_q - qsq) : '0;
				dsr_q <= cur_q.k;
			end
			ST_DIV_VAR: begin
				sx_q   <= rad;
				sres_q <= '0;
				sbit_q <= 64'h4000_0000_0000_0000;
				step_q <= '0;
			end
			ST_SQRT: begin
				if (s_take)
					sx_q <= sx_q - s_trial;
				sres_q <= sres_n;
				sbit_q <= sbit_q >> 2;
				step_q <= step_q + 5'd1;
				err_q  <= (sres_n > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sres_n[30:0];
			end
			ST_OUT: begin
				if (out_load) begin
					out_idx_q  <= cur_q.k;
					out_mean_q <= mean_q;
					out_err_q  <= err_q;
				end
			end
			default: ;
		endcase
	end

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_M || state_q == ST_DIV_MEAN
		                  || state_q == ST_DIV_A2 || state_q == ST_DIV_VAR))
		else $error("divider finished outside a divide wait");

	a_first_block_zero_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cur_q.k == '0) |-> err_q == '0)
		else $error("first block with nonzero error");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty block queue");

endmodule

@@ tb/sv/block_average_error_estimator_checker.sv @@
// watches the sample, result and register ports and predicts every block result
// depends on bae_pkg and the channel interfaces in bae_if
module block_average_error_estimator_checker
	import bae_pkg::*;
#(
	parameter int FRAC = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	bae_in_if           in_mon,
	bae_out_if          out_mon,
	output int          pending,
	output int          fails
);

	typedef struct {
		logic [15:0]        block_index;
		logic signed [31:0] running_mean;
		logic [30:0]        std_error;
	} block_result_t;

	block_result_t result_q[$];

	logic [15:0]        block_len;
	logic [15:0]        run_blocks;
	longint             acc_sum;
	int unsigned        taken;
	int unsigned        finished;
	longint             means_sum;
	logic [63:0]        squares_sum;

	function automatic logic [63:0] square_q(longint v);
		logic [63:0] a;
		a = (v < 0) ? 64'(-v) : 64'(v);
		return (a * a) >> FRAC;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe = probe >> 2;
		while (probe != 0) begin
			if (x >= res + probe) begin
				x = x - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	task automatic clear_run();
		acc_sum = 0;
		taken = 0;
		finished = 0;
		means_sum = 0;
		squares_sum = 0;
	endtask

	task automatic take_sample(logic signed [31:0] s, logic rst);
		longint      len;
		longint      m;
		longint      mean;
		logic [63:0] sq;
		logic [63:0] a2;
		logic [63:0] q;
		logic [63:0] var_q;
		logic [63:0] rad;
		logic [63:0] err;
		int unsigned cnt;
		int unsigned k;
		block_result_t r;
		len = (block_len == 0) ? 1 : longint'(block_len);
		if (rst)
			clear_run();
		if (finished >= run_blocks)
			return;
		acc_sum = acc_sum + longint'(s);
		cnt = taken + 1;
		if (longint'(cnt) < len) begin
			taken = cnt;
			return;
		end
		m = acc_sum / longint'(cnt);
		acc_sum = 0;
		taken = 0;
		means_sum = means_sum + m;
		sq = square_q(m);
		if (squares_sum > ~64'd0 - sq)
			squares_sum = ~64'd0;
		else
			squares_sum = squares_sum + sq;
		k = finished;
		finished = k + 1;
		mean = means_sum / longint'(finished);
		err = 0;
		if (k != 0) begin
			a2 = squares_sum / 64'(finished);
			q = square_q(mean);
			var_q = (a2 > q) ? (a2 - q) / 64'(k) : 64'd0;
			rad = (var_q > (~64'd0 >> FRAC)) ? ~64'd0 : var_q << FRAC;
			err = root64(rad);
			if (err > 64'h7FFF_FFFF)
				err = 64'h7FFF_FFFF;
		end
		r.block_index = k[15:0];
		r.running_mean = mean[31:0];
		r.std_error = err[30:0];
		result_q.insert(result_q.size(), r);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		block_result_t e;
		if (!arst_n) begin
			block_len <= BLOCK_LENGTH_RESET;
			run_blocks <= NUM_BLOCKS_RESET;
			clear_run();
			result_q.delete();
			pending <= 0;
			fails = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (result_q.size() == 0) begin
					report("unexpected block result, index", out_mon.block_index, -1);
				end else begin
					e = result_q.pop_front();
					if (out_mon.block_index !== e.block_index)
						report("block_index", out_mon.block_index, e.block_index);
					if (out_mon.running_mean !== e.running_mean)
						report("running_mean", out_mon.running_mean, e.running_mean);
					if (out_mon.std_error !== e.std_error)
						report("std_error", out_mon.std_error, e.std_error);
				end
			end
			if (in_mon.valid && in_mon.ready)
				take_sample(in_mon.sample, in_mon.restart);
			// register writes land after the sample of the same edge
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_BLOCK_LENGTH)
					block_len <= pwdata[15:0];
				else
					run_blocks <= pwdata[15:0];
			end
			pending <= result_q.size();
		end
	end

endmodule

@@ tb/sv/block_average_error_estimator_test.sv @@
// stimulus and verdict for the block average error estimator
// depends on bae_pkg, bae_if, the estimator and its checker
module block_average_error_estimator_test;
	import bae_pkg::*;

	localparam int STALL_LIMIT = 12000;
	localparam int SETTLE = 400;
	localparam int CHOKE_CYCLES = 1500;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          pending;
	int          fails;
	int          quiet;
	bit          calm;
	bit          choke_req;
	bit          choke_done;
	int          hold_left;
	int          gap_left;

	bae_in_if  in_ch ();
	bae_out_if out_ch ();

	block_average_error_estimator dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	block_average_error_estimator_checker chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .in_mon(in_ch), .out_mon(out_ch),
		.pending(pending), .fails(fails)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	// result side: random bursts of back-pressure, one long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			hold_left <= 0;
			gap_left <= 0;
			choke_done <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else if (choke_req && !choke_done) begin
			choke_done <= 1;
			hold_left <= CHOKE_CYCLES;
			out_ch.ready <= 0;
		end else if (calm) begin
			out_ch.ready <= 1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			out_ch.ready <= 0;
		end else if ($urandom_range(0, 5) == 0) begin
			gap_left <= $urandom_range(0, 3);
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= 1;
		end
	end

	// watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("block_average_error_estimator test failed");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [15:0] value);
		paddr = {idx, 2'b00};
		pwdata = {16'd0, value};
		pwrite = 1;
		psel = 1;
		penable = 0;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
	endtask

	task automatic setup(logic [15:0] len, logic [15:0] nblk);
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		write_reg(REG_BLOCK_LENGTH, len);
		write_reg(REG_NUM_BLOCKS, nblk);
	endtask

	// entered and left at a falling edge
	task automatic push(logic signed [31:0] s, logic rst);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 4);
			in_ch.valid = 0;
			repeat (n) @(negedge clk);
		end
		in_ch.valid = 1;
		in_ch.sample = s;
		in_ch.restart = rst;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_sample(logic signed [31:0] level);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 131071)) - 65536;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return level + $signed($urandom_range(0, 255)) - 128;
		endcase
	endfunction

	// each run starts from a cleared state
	task automatic random_run(int items, logic [15:0] len, logic [15:0] nblk);
		logic signed [31:0] level;
		setup(len, nblk);
		level = $urandom;
		for (int i = 0; i < items; i++)
			push(pick_sample(level), i == 0 || $urandom_range(0, 39) == 0);
		in_ch.valid = 0;
	endtask

	initial begin
		logic [15:0] len;
		logic [15:0] nblk;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_ch.valid = 0;
		in_ch.sample = 0;
		in_ch.restart = 0;
		calm = 0;
		choke_req = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// single-sample blocks: extremes, then equal means for a zero variance
		setup(1, 65535);
		push(32'sh7FFF_FFFF, 0);
		push(32'sh8000_0000, 0);
		push(0, 0);
		push(-1, 0);
		push(1, 0);
		push(32'sh0100_0000, 1);
		push(32'sh0100_0000, 0);
		push(32'sh0100_0000, 0);
		in_ch.valid = 0;
		// short run that finishes, ignored samples, then restart
		setup(2, 2);
		push(32'sh7FFF_FFFF, 0);
		push(32'sh7FFF_FFFF, 0);
		push(32'sh8000_0000, 0);
		push(5, 0);
		push(9, 0);
		push(3, 1);
		push(4, 0);
		in_ch.valid = 0;
		// zero block length counts as one, zero blocks ignores all
		setup(0, 3);
		push(100, 0);
		push(-200, 0);
		in_ch.valid = 0;
		setup(4, 0);
		push(7, 0);
		push(7, 1);
		in_ch.valid = 0;
		// length lowered partway through a block
		setup(8, 10);
		push(1000, 0);
		push(-3000, 0);
		push(50, 0);
		push(77, 0);
		push(-9, 0);
		in_ch.valid = 0;
		setup(3, 10);
		push(12345, 0);
		in_ch.valid = 0;

		// one long block in a one-block run, the rest ignored
		random_run(100, 97, 1);

		for (int p = 0; p < 6; p++) begin
			len = $urandom_range(1, 6);
			nblk = ($urandom_range(0, 2) == 0) ? 16'd65535 : 16'($urandom_range(1, 40));
			random_run(70, len, nblk);
		end
		// fill the block queue while the result side holds off
		setup(1, 65535);
		choke_req = 1;
		for (int i = 0; i < 60; i++)
			push(pick_sample(0), 0);
		in_ch.valid = 0;
		calm = 1;
		random_run(100, 2, 65535);

		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		if (fails == 0)
			$display("block_average_error_estimator test passed");
		else
			$display("block_average_error_estimator test failed");
		$finish;
	end

endmodule
